### hw/rtl/mcc_pkg.sv
package mcc_pkg;

  localparam int MAX_TARGET = 1023;
  localparam int COIN_SLOTS = 6;
  localparam int COIN_REGS  = 6;
  localparam int SLOTS_USED = (COIN_SLOTS < COIN_REGS) ? COIN_SLOTS : COIN_REGS;

  localparam int TARGET_W   = 10;
  localparam int COIN_W     = 10;
  localparam int COUNT_W    = 3;
  localparam int TOTAL_W    = 10;
  localparam int BEST_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int SLOT_W     = $clog2(COIN_REGS);
  localparam int TBL_DEPTH  = MAX_TARGET + 1;
  localparam int ADDR_W     = $clog2(TBL_DEPTH);

  localparam logic [BEST_W-1:0] BEST_UNREACHED = {BEST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COIN_COUNT = 3'd0,
    REG_COIN_A     = 3'd1,
    REG_COIN_B     = 3'd2,
    REG_COIN_C     = 3'd3,
    REG_COIN_D     = 3'd4,
    REG_COIN_E     = 3'd5,
    REG_COIN_F     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_INIT = 3'd1,
    ST_COIN = 3'd2,
    ST_FILL = 3'd3,
    ST_EMIT = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    ACT_WAIT,
    ACT_INIT,
    ACT_COIN,
    ACT_FILL,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_NO_START,
    JC_TRIVIAL,
    JC_MORE_COINS,
    JC_MORE_AMT
  } cond_t;

  // one control word: what the datapath does, and where to go if cond holds
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;
  } ctrl_t;

  // microprogram; when cond is false the step counter falls through by one
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t cw;
    unique case (s)
      ST_IDLE: cw = '{act: ACT_WAIT, cond: JC_NO_START,   jmp: ST_IDLE};
      ST_INIT: cw = '{act: ACT_INIT, cond: JC_TRIVIAL,    jmp: ST_EMIT};
      ST_COIN: cw = '{act: ACT_COIN, cond: JC_MORE_COINS, jmp: ST_COIN};
      ST_FILL: cw = '{act: ACT_FILL, cond: JC_MORE_AMT,   jmp: ST_COIN};
      ST_EMIT: cw = '{act: ACT_EMIT, cond: JC_ALWAYS,     jmp: ST_IDLE};
      default: cw = '{act: ACT_WAIT, cond: JC_ALWAYS,     jmp: ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### hw/rtl/mcc_ram.sv
module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/min_coin_change_dp_top.sv
// Fewest-coins engine. Pulse start while busy is low to hand in a request;
// the result shows on out_coin_total / out_no_solution for one cycle with
// out_valid high, after the table is filled up to in_target (a zero target
// skips the fill). Each amount from 1 to the target visits every coin slot
// and then writes its entry, all through the single read port of the
// 1024-entry best-count table. busy drops in the cycle the result shows, so
// the next request may be given then. The table needs no clearing after
// reset: every entry is written before it is read. Configuration writes are
// taken any time but belong in idle periods.
module min_coin_change_dp_top
  import mcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [TARGET_W-1:0]   in_target,
  output logic                  out_valid,
  output logic [TOTAL_W-1:0]    out_coin_total,
  output logic                  out_no_solution,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [COUNT_W-1:0] coin_count_r;
  logic [COIN_W-1:0]  coin_r [COIN_REGS];

  // sequencer
  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  taken;

  // datapath
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [TARGET_W-1:0] amt_r, amt_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic [BEST_W-1:0]   best_r, best_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                out_nosol_r, out_nosol_nxt;

  logic [COUNT_W-1:0]  ncoins;
  logic [COIN_W-1:0]   coin_sel;
  logic                usable;
  logic                over;
  logic                trivial;
  logic                more_coins;
  logic                more_amt;
  logic [BEST_W-1:0]   rdata;
  logic [BEST_W-1:0]   best_cand;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [BEST_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= '0;
      for (int i = 0; i < COIN_REGS; i++) begin
        coin_r[i] <= (i == 0) ? COIN_W'(1) : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COIN_COUNT: coin_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_COIN_A:     coin_r[0]    <= cfg_wdata[COIN_W-1:0];
        REG_COIN_B:     coin_r[1]    <= cfg_wdata[COIN_W-1:0];
        REG_COIN_C:     coin_r[2]    <= cfg_wdata[COIN_W-1:0];
        REG_COIN_D:     coin_r[3]    <= cfg_wdata[COIN_W-1:0];
        REG_COIN_E:     coin_r[4]    <= cfg_wdata[COIN_W-1:0];
        REG_COIN_F:     coin_r[5]    <= cfg_wdata[COIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign ncoins     = (coin_count_r > COUNT_W'(SLOTS_USED)) ? COUNT_W'(SLOTS_USED)
                                                            : coin_count_r;
  assign coin_sel   = coin_r[k_r];
  assign usable     = (COUNT_W'(k_r) < ncoins) && (coin_sel != '0) && (coin_sel <= amt_r);
  assign over       = int'(target_r) > MAX_TARGET;
  assign trivial    = (target_r == '0) || over;
  assign more_coins = k_r != SLOT_W'(SLOTS_USED - 1);
  assign more_amt   = amt_r != target_r;

  // fold the entry read in the previous step into the running minimum
  assign best_cand = (pend_r && (rdata != BEST_UNREACHED) && ((rdata + BEST_W'(1)) < best_r))
                     ? rdata + BEST_W'(1) : best_r;

  assign cw = ucode(step_r);

  always_comb begin
    case (cw.cond)
      JC_ALWAYS:     taken = 1'b1;
      JC_NO_START:   taken = !start;
      JC_TRIVIAL:    taken = trivial;
      JC_MORE_COINS: taken = more_coins;
      JC_MORE_AMT:   taken = more_amt;
      default:       taken = 1'b1;
    endcase
    step_nxt = taken ? cw.jmp : step_t'(3'(step_r + 3'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    amt_r       <= amt_nxt;
    k_r         <= k_nxt;
    best_r      <= best_nxt;
    pend_r      <= pend_nxt;
    out_total_r <= out_total_nxt;
    out_nosol_r <= out_nosol_nxt;
  end

  always_comb begin
    target_nxt    = target_r;
    amt_nxt       = amt_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_total_nxt = out_total_r;
    out_nosol_nxt = out_nosol_r;
    mem_we        = 1'b0;
    mem_waddr     = ADDR_W'(amt_r);
    mem_wdata     = best_cand;
    mem_raddr     = ADDR_W'(amt_r - coin_sel);

    unique case (cw.act)
      ACT_WAIT: begin
        if (start) begin
          target_nxt = in_target;
        end
      end
      ACT_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '0;
        amt_nxt   = TARGET_W'(1);
        k_nxt     = '0;
        pend_nxt  = 1'b0;
        best_nxt  = (target_r == '0 && !over) ? '0 : BEST_UNREACHED;
      end
      ACT_COIN: begin
        best_nxt = best_cand;
        pend_nxt = usable;
        k_nxt    = SLOT_W'(k_r + SLOT_W'(1));
      end
      ACT_FILL: begin
        mem_we = 1'b1;
        if (more_amt) begin
          amt_nxt  = TARGET_W'(amt_r + TARGET_W'(1));
          best_nxt = BEST_UNREACHED;
          k_nxt    = '0;
          pend_nxt = 1'b0;
        end else begin
          best_nxt = best_cand;
        end
      end
      ACT_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nosol_nxt = best_r == BEST_UNREACHED;
        out_total_nxt = (best_r == BEST_UNREACHED) ? '0 : best_r[TOTAL_W-1:0];
      end
      default: ;
    endcase
  end

  mcc_ram #(
    .WIDTH(BEST_W),
    .DEPTH(TBL_DEPTH)
  ) u_best_tbl (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign busy            = step_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_coin_total  = out_total_r;
  assign out_no_solution = out_nosol_r;

endmodule

### hw/rtl/mcc_chk.sv
module mcc_chk
  import mcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [TARGET_W-1:0]   in_target,
  input logic                  out_valid,
  input logic [TOTAL_W-1:0]    out_coin_total,
  input logic                  out_no_solution
);

  // a taken request keeps the engine busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but engine not busy");

  // one strobe per request, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in flight");

  a_nosol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_solution |-> out_coin_total == '0)
    else $error("no_solution with nonzero count");

  // zero target takes the short path
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_target == '0 |-> ##3 (out_valid && !out_no_solution
                                               && out_coin_total == '0))
    else $error("zero target result wrong or late");

endmodule

bind min_coin_change_dp_top mcc_chk u_mcc_chk (.*);
